[hw/rtl/fluvial_erosion_deposition_step_unit_macros.svh]
// Assertion macros shared by the erosion and deposition step unit.
`ifndef FLUVIAL_EROSION_DEPOSITION_STEP_UNIT_MACROS_SVH
`define FLUVIAL_EROSION_DEPOSITION_STEP_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Checks a property at every rising clock edge outside reset.
`define FEDSU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checks that a condition never holds outside reset.
`define FEDSU_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define FEDSU_ASSERT(lbl, prop, msg)
`define FEDSU_NEVER(lbl, expr, msg)
`endif

`endif

[hw/rtl/fedsu_pkg.sv]
// Types, constants and helper functions of the erosion and deposition step unit.
`timescale 1ns / 1ps

package fedsu_pkg;

    // Node store geometry.
    localparam int NODE_COUNT = 65536;
    localparam int NODE_AW    = $clog2(NODE_COUNT);

    // Field and datapath widths.
    localparam int FLUX_W   = 48;
    localparam int RAM_W    = FLUX_W + 1;
    localparam int LEN_W    = 36;
    localparam int MUL_A_W  = 80;
    localparam int MUL_B_W  = 32;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int MUL_CW   = $clog2(MUL_B_W);
    localparam int DIV_W    = 96;
    localparam int DIV_D_W  = 40;
    localparam int DIV_N_W  = $clog2(DIV_W + 1);
    localparam int PADDR_W  = 4;

    // Configuration register indexes.
    localparam logic [1:0] REG_ERODIBILITY     = 2'd0;
    localparam logic [1:0] REG_SEA_LEVEL       = 2'd1;
    localparam logic [1:0] REG_SEDIMENT_LENGTH = 2'd2;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_M1,
        S_M2,
        S_DQ,
        S_LEN,
        S_MD,
        S_E1,
        S_E2,
        S_EX,
        S_DCH,
        S_RR,
        S_RW,
        S_OUT
    } state_t;

    // Request to the serial multiplier.
    typedef struct packed {
        logic               go;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    // Request to the serial divider; the dividend is left aligned to its steps.
    typedef struct packed {
        logic               go;
        logic [DIV_N_W-1:0] steps;
        logic [DIV_W-1:0]   dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    // Saturates a quotient to the flux width.
    function automatic logic [FLUX_W-1:0] sat_flux(input logic [DIV_W-1:0] v);
        logic [FLUX_W-1:0] r;
        if (|v[DIV_W-1:FLUX_W]) r = '1;
        else r = v[FLUX_W-1:0];
        return r;
    endfunction

endpackage

[hw/rtl/fedsu_ram.sv]
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps

module fedsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/fedsu_mul.sv]
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module fedsu_mul (
    input  logic                      clk,
    input  logic                      rst_n,
    input  fedsu_pkg::mul_req_t       req,
    output logic                      done,
    output logic [fedsu_pkg::MUL_P_W-1:0] prod
);

    import fedsu_pkg::*;

    logic [MUL_P_W-1:0] p_reg, p_next;
    logic [MUL_A_W-1:0] a_reg, a_next;
    logic [MUL_CW-1:0]  cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [MUL_A_W:0]   sum;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        a_reg <= a_next;
    end

    // One step adds the multiplicand to the upper part when the low bit is set, and shifts right.
    always_comb
    begin
        sum       = {1'b0, p_reg[MUL_P_W-1:MUL_B_W]} + ({(MUL_A_W+1){p_reg[0]}} & {1'b0, a_reg});
        p_next    = p_reg;
        a_next    = a_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (req.go)
        begin
            a_next   = req.a;
            p_next   = {{MUL_A_W{1'b0}}, req.b};
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            p_next   = {sum, p_reg[MUL_B_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CW'(MUL_B_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign prod = p_reg;

endmodule

[hw/rtl/fedsu_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module fedsu_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  fedsu_pkg::div_req_t       req,
    output logic                      done,
    output logic [fedsu_pkg::DIV_W-1:0] quot
);

    import fedsu_pkg::*;

    logic [DIV_W-1:0]   q_reg, q_next;
    logic [DIV_D_W:0]   r_reg, r_next;
    logic [DIV_D_W-1:0] d_reg, d_next;
    logic [DIV_N_W-1:0] cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [DIV_D_W:0]   r_sh;
    logic               fits;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    // Shift one dividend bit into the remainder and subtract when it fits.
    always_comb
    begin
        r_sh      = {r_reg[DIV_D_W-1:0], q_reg[DIV_W-1]};
        fits      = (r_sh >= {1'b0, d_reg});
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (req.go)
        begin
            q_next   = req.dividend;
            r_next   = '0;
            d_next   = req.divisor;
            cnt_next = req.steps - 1'b1;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            r_next   = fits ? (r_sh - {1'b0, d_reg}) : r_sh;
            q_next   = {q_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

[hw/rtl/fluvial_erosion_deposition_step_unit.sv]
// One request is in work at a time. The rate is set by the shared bit-serial divider
// (one quotient bit per cycle, up to 92 steps) and the shared bit-serial multiplier
// (32-bit multiplier operand, one multiplier bit per step).
// After reset the flux store is cleared with busy high; results are strobed on done for
// one cycle and the receiver cannot stall them.
`timescale 1ns / 1ps
`include "fluvial_erosion_deposition_step_unit_macros.svh"

module fluvial_erosion_deposition_step_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // Request channel.
    input  logic                          start,
    output logic                          busy,
    input  logic [15:0]                   node,
    input  logic [15:0]                   receiver,
    input  logic signed [31:0]            height,
    input  logic signed [31:0]            receiver_height,
    input  logic [fedsu_pkg::FLUX_W-1:0]  runoff,
    input  logic [31:0]                   flow_distance,
    input  logic [39:0]                   cell_area,
    input  logic signed [31:0]            bedrock_height,
    input  logic [15:0]                   lithology_factor,
    input  logic [31:0]                   bedrock_length,
    input  logic                          modifiable,
    input  logic                          first_of_pass,
    // Result channel.
    output logic                          done,
    output logic [15:0]                   node_out,
    output logic signed [31:0]            height_change,
    output logic signed [31:0]            new_height,
    output logic [fedsu_pkg::FLUX_W-1:0]  flux_out,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fedsu_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    import fedsu_pkg::*;

    localparam int DEP_SHIFT = 12 + DIV_W - 60;
    localparam int QEQ_SHIFT = DIV_W - 72;
    localparam int E1_SHIFT  = 12 + DIV_W - 92;
    localparam int E2_SHIFT  = DIV_W - 92;
    localparam int EX_SHIFT  = DIV_W - 80;

    state_t state_reg, state_next;

    logic                    pass_reg, pass_next;
    logic [NODE_AW-1:0]      clr_reg, clr_next;
    logic [31:0]             erod_reg;
    logic signed [31:0]      sea_reg;
    logic [31:0]             slen_reg;

    logic [15:0]             node_reg, node_next;
    logic [15:0]             recv_reg, recv_next;
    logic signed [31:0]      h_reg, h_next;
    logic signed [31:0]      rh_reg, rh_next;
    logic [FLUX_W-1:0]       runoff_reg, runoff_next;
    logic [31:0]             dist_reg, dist_next;
    logic [39:0]             area_reg, area_next;
    logic signed [31:0]      bed_reg, bed_next;
    logic [15:0]             lith_reg, lith_next;
    logic [31:0]             blen_reg, blen_next;
    logic                    modif_reg, modif_next;
    logic                    outlet_reg, outlet_next;
    logic [FLUX_W-1:0]       qin_reg, qin_next;
    logic [FLUX_W-1:0]       diff_reg, diff_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic [MUL_A_W-1:0]      prod_reg, prod_next;
    logic [31:0]             chg_reg, chg_next;
    logic [FLUX_W-1:0]       fout_reg, fout_next;

    mul_req_t                mul_req;
    logic                    mul_done;
    logic [MUL_P_W-1:0]      mul_p;
    div_req_t                div_req;
    logic                    div_done;
    logic [DIV_W-1:0]        div_q;

    logic                    ram_we;
    logic [NODE_AW-1:0]      ram_waddr;
    logic [RAM_W-1:0]        ram_wdata;
    logic [NODE_AW-1:0]      ram_raddr;
    logic [RAM_W-1:0]        ram_rdata;

    logic [FLUX_W-1:0]       flux_rd;
    logic                    node_ok;
    logic                    recv_ok;
    logic                    outlet;
    logic signed [32:0]      h_m_rh;
    logic signed [32:0]      h_m_sea;
    logic [31:0]             dh;
    logic [FLUX_W-1:0]       qeq;
    logic [LEN_W-1:0]        len_sel;
    logic [31:0]             mag;
    logic [FLUX_W:0]         fsum;
    logic [FLUX_W:0]         rsum;
    logic signed [32:0]      nh_sum;
    logic                    cfg_we;
    logic [1:0]              cfg_idx;

    // Shared arithmetic units and the flux store.
    fedsu_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .done  (mul_done),
        .prod  (mul_p)
    );

    fedsu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_q)
    );

    fedsu_ram #(
        .WIDTH (RAM_W),
        .DEPTH (NODE_COUNT)
    ) u_flux_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Configuration registers.
    assign cfg_idx = paddr[PADDR_W-1:2];
    assign cfg_we  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            erod_reg <= '0;
            sea_reg  <= '0;
            slen_reg <= 32'd4096;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_ERODIBILITY:     erod_reg <= pwdata;
                REG_SEA_LEVEL:       sea_reg  <= pwdata;
                REG_SEDIMENT_LENGTH: slen_reg <= pwdata;
                default:             ;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        unique case (cfg_idx)
            REG_ERODIBILITY:     prdata = erod_reg;
            REG_SEA_LEVEL:       prdata = sea_reg;
            REG_SEDIMENT_LENGTH: prdata = slen_reg;
            default:             prdata = '0;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            pass_reg  <= 1'b0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            clr_reg   <= clr_next;
        end
    end

    // Request and working registers.
    always_ff @(posedge clk)
    begin
        node_reg   <= node_next;
        recv_reg   <= recv_next;
        h_reg      <= h_next;
        rh_reg     <= rh_next;
        runoff_reg <= runoff_next;
        dist_reg   <= dist_next;
        area_reg   <= area_next;
        bed_reg    <= bed_next;
        lith_reg   <= lith_next;
        blen_reg   <= blen_next;
        modif_reg  <= modif_next;
        outlet_reg <= outlet_next;
        qin_reg    <= qin_next;
        diff_reg   <= diff_next;
        len_reg    <= len_next;
        prod_reg   <= prod_next;
        chg_reg    <= chg_next;
        fout_reg   <= fout_next;
    end

    // Values derived from the current request.
    always_comb
    begin
        flux_rd = (ram_rdata[FLUX_W] == pass_reg) ? ram_rdata[FLUX_W-1:0] : '0;
        node_ok = (32'(node_reg) < 32'(NODE_COUNT));
        recv_ok = (32'(recv_reg) < 32'(NODE_COUNT));
        outlet  = (recv_reg != node_reg) && (h_reg > rh_reg);
        h_m_rh  = 33'(h_reg) - 33'(rh_reg);
        h_m_sea = 33'(h_reg) - 33'(sea_reg);
        dh      = ((rh_reg > sea_reg) || (h_reg < sea_reg)) ? h_m_rh[31:0] : h_m_sea[31:0];
        qeq     = sat_flux(div_q);
        len_sel = (bed_reg < h_reg) ? mul_p[LEN_W+11:12] : LEN_W'(blen_reg);
        mag     = (|div_q[DIV_W-1:32]) ? 32'hFFFF_FFFF : div_q[31:0];
        if (mag > 32'h8000_0000)
        begin
            mag = 32'h8000_0000;
        end
        fsum    = {1'b0, qin_reg} + {1'b0, sat_flux(div_q)};
        rsum    = {1'b0, (recv_ok ? flux_rd : '0)} + {1'b0, fout_reg};
    end

    // Sequencer: next state, unit launches and store accesses.
    always_comb
    begin
        state_next  = state_reg;
        pass_next   = pass_reg;
        clr_next    = clr_reg;
        node_next   = node_reg;
        recv_next   = recv_reg;
        h_next      = h_reg;
        rh_next     = rh_reg;
        runoff_next = runoff_reg;
        dist_next   = dist_reg;
        area_next   = area_reg;
        bed_next    = bed_reg;
        lith_next   = lith_reg;
        blen_next   = blen_reg;
        modif_next  = modif_reg;
        outlet_next = outlet_reg;
        qin_next    = qin_reg;
        diff_next   = diff_reg;
        len_next    = len_reg;
        prod_next   = prod_reg;
        chg_next    = chg_reg;
        fout_next   = fout_reg;
        mul_req     = '0;
        div_req     = '0;
        ram_we      = 1'b0;
        ram_waddr   = NODE_AW'(recv_reg);
        ram_wdata   = '0;
        ram_raddr   = NODE_AW'(recv_reg);
        done        = 1'b0;

        unique case (state_reg)
            // Clear every store entry once after reset.
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == NODE_AW'(NODE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            // Take a request and read the node's incoming flux.
            S_IDLE:
            begin
                ram_raddr = NODE_AW'(node);
                if (start)
                begin
                    node_next   = node;
                    recv_next   = receiver;
                    h_next      = height;
                    rh_next     = receiver_height;
                    runoff_next = runoff;
                    dist_next   = (flow_distance == '0) ? 32'd1 : flow_distance;
                    area_next   = (cell_area == '0) ? 40'd1 : cell_area;
                    bed_next    = bedrock_height;
                    lith_next   = lithology_factor;
                    blen_next   = bedrock_length;
                    modif_next  = modifiable;
                    pass_next   = pass_reg ^ first_of_pass;
                    state_next  = S_RD;
                end
            end

            // Capture the incoming flux and start on the equilibrium flux, or without outlet on the height gain.
            S_RD:
            begin
                qin_next    = node_ok ? flux_rd : '0;
                outlet_next = outlet;
                fout_next   = '0;
                if (outlet)
                begin
                    mul_req.go = 1'b1;
                    mul_req.a  = MUL_A_W'(runoff_reg);
                    mul_req.b  = erod_reg;
                    state_next = S_M1;
                end
                else
                begin
                    div_req.go       = 1'b1;
                    div_req.steps    = DIV_N_W'(60);
                    div_req.dividend = DIV_W'(node_ok ? flux_rd : '0) << DEP_SHIFT;
                    div_req.divisor  = area_reg;
                    state_next       = S_DCH;
                end
            end

            // Erodibility times runoff, then times the drop.
            S_M1:
            begin
                if (mul_done)
                begin
                    mul_req.go = 1'b1;
                    mul_req.a  = mul_p[MUL_A_W-1:0];
                    mul_req.b  = dh;
                    state_next = S_M2;
                end
            end

            // Scale down the fraction and divide by the distance.
            S_M2:
            begin
                if (mul_done)
                begin
                    div_req.go       = 1'b1;
                    div_req.steps    = DIV_N_W'(72);
                    div_req.dividend = DIV_W'(mul_p >> 40) << QEQ_SHIFT;
                    div_req.divisor  = DIV_D_W'(dist_reg);
                    state_next       = S_DQ;
                end
            end

            // Choose between deposition and erosion.
            S_DQ:
            begin
                if (div_done)
                begin
                    if (qeq <= qin_reg)
                    begin
                        fout_next        = qeq;
                        div_req.go       = 1'b1;
                        div_req.steps    = DIV_N_W'(60);
                        div_req.dividend = DIV_W'(qin_reg - qeq) << DEP_SHIFT;
                        div_req.divisor  = area_reg;
                        state_next       = S_DCH;
                    end
                    else
                    begin
                        diff_next  = qeq - qin_reg;
                        mul_req.go = 1'b1;
                        mul_req.a  = MUL_A_W'(slen_reg);
                        mul_req.b  = MUL_B_W'(lith_reg);
                        state_next = S_LEN;
                    end
                end
            end

            // Pick the transport length, then form deficit times distance.
            S_LEN:
            begin
                if (mul_done)
                begin
                    len_next   = (len_sel == '0) ? LEN_W'(1) : len_sel;
                    mul_req.go = 1'b1;
                    mul_req.a  = MUL_A_W'(diff_reg);
                    mul_req.b  = dist_reg;
                    state_next = S_MD;
                end
            end

            // Erosion depth: first divide by the cell area.
            S_MD:
            begin
                if (mul_done)
                begin
                    prod_next        = mul_p[MUL_A_W-1:0];
                    div_req.go       = 1'b1;
                    div_req.steps    = DIV_N_W'(92);
                    div_req.dividend = DIV_W'(mul_p[MUL_A_W-1:0]) << E1_SHIFT;
                    div_req.divisor  = area_reg;
                    state_next       = S_E1;
                end
            end

            // Then divide by the transport length.
            S_E1:
            begin
                if (div_done)
                begin
                    div_req.go       = 1'b1;
                    div_req.steps    = DIV_N_W'(92);
                    div_req.dividend = div_q << E2_SHIFT;
                    div_req.divisor  = DIV_D_W'(len_reg);
                    state_next       = S_E2;
                end
            end

            // Negate the capped depth and form the extra flux.
            S_E2:
            begin
                if (div_done)
                begin
                    chg_next         = ~mag + 32'd1;
                    div_req.go       = 1'b1;
                    div_req.steps    = DIV_N_W'(80);
                    div_req.dividend = DIV_W'(prod_reg) << EX_SHIFT;
                    div_req.divisor  = DIV_D_W'(len_reg);
                    state_next       = S_EX;
                end
            end

            // Outgoing flux is the incoming flux plus what was eroded.
            S_EX:
            begin
                if (div_done)
                begin
                    fout_next  = fsum[FLUX_W] ? '1 : fsum[FLUX_W-1:0];
                    state_next = S_RR;
                end
            end

            // Deposition or no outlet: saturate the height gain.
            S_DCH:
            begin
                if (div_done)
                begin
                    chg_next   = (div_q > DIV_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_q[31:0];
                    state_next = outlet_reg ? S_RR : S_OUT;
                end
            end

            // Read the receiver's entry.
            S_RR:
            begin
                state_next = S_RW;
            end

            // Add the outgoing flux to the receiver's entry.
            S_RW:
            begin
                ram_we    = recv_ok;
                ram_wdata = {pass_reg, (rsum[FLUX_W] ? {FLUX_W{1'b1}} : rsum[FLUX_W-1:0])};
                state_next = S_OUT;
            end

            // Present the result for one cycle.
            S_OUT:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
        endcase
    end

    // Result fields.
    always_comb
    begin
        nh_sum = 33'(h_reg) + 33'(signed'(chg_reg));
        if (!modif_reg)
        begin
            new_height = h_reg;
        end
        else if (nh_sum[32] != nh_sum[31])
        begin
            new_height = nh_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            new_height = nh_sum[31:0];
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign node_out      = node_reg;
    assign height_change = chg_reg;
    assign flux_out      = fout_reg;

    // Checks on the sequencer.
    `FEDSU_ASSERT(a_done_single, done |=> !done, "result strobe lasted more than one cycle")
    `FEDSU_ASSERT(a_start_busy, (start && !busy) |=> busy, "request accepted without busy")
    `FEDSU_NEVER(a_units_excl, mul_req.go && div_req.go, "multiplier and divider launched together")
    `FEDSU_NEVER(a_idle_write, ram_we && (state_reg == S_IDLE), "flux store written while idle")

endmodule
